/* rtl/fifo_handoff_lock_unit_macros.svh */
// assertion macros used by the checker file
`ifndef FIFO_HANDOFF_LOCK_UNIT_MACROS_SVH
`define FIFO_HANDOFF_LOCK_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define FHL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define FHL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/fhl_pkg.sv */
package fhl_pkg;

   // request kinds
   localparam logic [1:0] ACT_INIT    = 2'd0;
   localparam logic [1:0] ACT_LOCK    = 2'd1;
   localparam logic [1:0] ACT_UNLOCK  = 2'd2;
   localparam logic [1:0] ACT_DESTROY = 2'd3;

   // result codes
   localparam logic [3:0] ST_GRANTED = 4'd0;
   localparam logic [3:0] ST_QUEUED  = 4'd1;
   localparam logic [3:0] ST_HANDED  = 4'd2;
   localparam logic [3:0] ST_FREED   = 4'd3;
   localparam logic [3:0] ST_IGNORED = 4'd4;
   localparam logic [3:0] ST_UNINIT  = 4'd5;
   localparam logic [3:0] ST_FULL    = 4'd6;
   localparam logic [3:0] ST_OWNED   = 4'd7;
   localparam logic [3:0] ST_INIT    = 4'd8;
   localparam logic [3:0] ST_DESTROY = 4'd9;

   // queue control travelling from the lock logic to every cell
   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } qctl_type;

endpackage

/* rtl/fhl_cell.sv */
module fhl_cell #(
   parameter int IdW = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  fhl_pkg::qctl_type  ctl,
   input  logic [IdW-1:0]     push_id,
   input  logic               prev_valid,
   input  logic               next_valid,
   input  logic [IdW-1:0]     next_id,
   output logic               valid,
   output logic [IdW-1:0]     id
);
   import fhl_pkg::*;

   logic           valid_ff, valid_in;
   logic [IdW-1:0] id_ff, id_in;
   logic           take_push;

   // a push lands in the first empty cell: the head cell, or one behind an occupied one
   assign take_push = ctl.push && prev_valid && !valid_ff;

   // empty on clear, shift towards the head on pop, load on push, else hold
   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.pop) begin
         valid_in = next_valid;
         id_in    = next_id;
      end else if (take_push) begin
         valid_in = 1'b1;
         id_in    = push_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

   assign valid = valid_ff;
   assign id    = id_ff;

endmodule

/* rtl/fhl_queue.sv */
module fhl_queue #(
   parameter int Depth = 16,
   parameter int IdW   = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  fhl_pkg::qctl_type  ctl,
   input  logic [IdW-1:0]     push_id,
   output logic [IdW-1:0]     head_id,
   output logic               empty,
   output logic               full
);
   import fhl_pkg::*;

   logic [Depth-1:0] cell_valid;
   logic [IdW-1:0]   cell_id [Depth];

   // row of cells, cell zero holds the head of the queue
   for (genvar i = 0; i < Depth; i++) begin : g_cell
      logic           prev_v;
      logic           next_v;
      logic [IdW-1:0] next_i;

      if (i == 0) begin : g_first
         assign prev_v = 1'b1;
      end else begin : g_mid
         assign prev_v = cell_valid[i-1];
      end

      if (i == Depth - 1) begin : g_last
         assign next_v = 1'b0;
         assign next_i = '0;
      end else begin : g_inner
         assign next_v = cell_valid[i+1];
         assign next_i = cell_id[i+1];
      end

      fhl_cell #(.IdW(IdW)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .push_id    (push_id),
         .prev_valid (prev_v),
         .next_valid (next_v),
         .next_id    (next_i),
         .valid      (cell_valid[i]),
         .id         (cell_id[i])
      );
   end

   assign head_id = cell_id[0];
   assign empty   = !cell_valid[0];
   assign full    = cell_valid[Depth-1];

endmodule

/* rtl/fifo_handoff_lock_unit.sv */
// Hardware mutex with first-in first-out handoff. Each transaction on the req_
// side carries a request kind (init, lock, unlock, destroy) and a requester id;
// exactly one result transaction follows on the rsp_ side with a status code and
// the owner after the request. A request is decided in the cycle it is taken and
// its result is registered, so the unit takes one request per clock cycle and
// the result appears in the cycle after acceptance; the rate is set by the single
// result register, which frees as soon as rsp_tready takes its contents. Waiters
// sit in a row of QUEUE_DEPTH cells that shift towards the head on each handoff.
// Only the low ID_BITS bits of the requester id are kept (at most eight).
module fifo_handoff_lock_unit #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // requester[7:0]
   input  logic [1:0] req_tuser,   // action[1:0]
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // holder[7:0]
   output logic [4:0] rsp_tuser    // status[3:0], holder_valid[4]
);
   import fhl_pkg::*;

   localparam int IdW = (ID_BITS < 8) ? ID_BITS : 8;

   logic           ready_ff, ready_in;
   logic           held_ff, held_in;
   logic [IdW-1:0] holder_ff, holder_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [3:0]     rsp_status_ff, rsp_status_in;
   logic           rsp_held_ff;
   logic [IdW-1:0] rsp_holder_ff;

   logic           accept;
   logic [IdW-1:0] rid;
   logic [IdW-1:0] head_id;
   logic           q_empty, q_full;
   qctl_type       qctl;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rid        = req_tdata[IdW-1:0];

   // wait queue
   fhl_queue #(.Depth(QUEUE_DEPTH), .IdW(IdW)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .ctl     (qctl),
      .push_id (rid),
      .head_id (head_id),
      .empty   (q_empty),
      .full    (q_full)
   );

   // request decision
   always_comb begin
      ready_in      = ready_ff;
      held_in       = held_ff;
      holder_in     = holder_ff;
      qctl          = '0;
      rsp_status_in = ST_INIT;
      unique case (req_tuser)
         ACT_INIT: begin
            ready_in   = 1'b1;
            held_in    = 1'b0;
            holder_in  = '0;
            qctl.clear = 1'b1;
         end
         ACT_LOCK: begin
            if (!ready_ff) begin
               rsp_status_in = ST_UNINIT;
            end else if (!held_ff) begin
               held_in       = 1'b1;
               holder_in     = rid;
               rsp_status_in = ST_GRANTED;
            end else if (holder_ff == rid) begin
               rsp_status_in = ST_GRANTED;
            end else if (q_full) begin
               rsp_status_in = ST_FULL;
            end else begin
               qctl.push     = 1'b1;
               rsp_status_in = ST_QUEUED;
            end
         end
         ACT_UNLOCK: begin
            if (!ready_ff) begin
               rsp_status_in = ST_UNINIT;
            end else if (!held_ff) begin
               rsp_status_in = ST_IGNORED;
            end else if (!q_empty) begin
               holder_in     = head_id;
               qctl.pop      = 1'b1;
               rsp_status_in = ST_HANDED;
            end else begin
               held_in       = 1'b0;
               holder_in     = '0;
               rsp_status_in = ST_FREED;
            end
         end
         ACT_DESTROY: begin
            if (held_ff) begin
               rsp_status_in = ST_OWNED;
            end else begin
               ready_in      = 1'b0;
               holder_in     = '0;
               qctl.clear    = 1'b1;
               rsp_status_in = ST_DESTROY;
            end
         end
         default: begin
            rsp_status_in = ST_INIT;
         end
      endcase
      if (!accept) begin
         ready_in  = ready_ff;
         held_in   = held_ff;
         holder_in = holder_ff;
         qctl      = '0;
      end
   end

   // result register occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff     <= 1'b0;
         held_ff      <= 1'b0;
         holder_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ready_ff     <= ready_in;
         held_ff      <= held_in;
         holder_ff    <= holder_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_held_ff   <= held_in;
         rsp_holder_ff <= held_in ? holder_in : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 8'(rsp_holder_ff);
   assign rsp_tuser  = {rsp_held_ff, rsp_status_ff};

endmodule

/* rtl/fhl_checker.sv */
`include "fifo_handoff_lock_unit_macros.svh"

module fhl_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [4:0] rsp_tuser
);
   import fhl_pkg::*;

   // a stalled result keeps its contents
   `FHL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   // every accepted request shows its result in the next cycle
   `FHL_ASSERT_NEXT(a_rsp_follows, clock, reset, req_tvalid && req_tready,
      rsp_tvalid, "no result after accepted request")

   // no owner means the holder reads as zero
   `FHL_ASSERT_NOW(a_holder_zero, clock, reset, rsp_tvalid && !rsp_tuser[4],
      rsp_tdata == 8'd0, "holder not zero without owner")

   // a grant or a handoff always leaves an owner
   `FHL_ASSERT_NOW(a_owner_set, clock, reset,
      rsp_tvalid && (rsp_tuser[3:0] == ST_GRANTED || rsp_tuser[3:0] == ST_HANDED),
      rsp_tuser[4], "grant without owner")

   // freeing, init and destroy leave no owner
   `FHL_ASSERT_NOW(a_owner_clear, clock, reset,
      rsp_tvalid && (rsp_tuser[3:0] == ST_FREED || rsp_tuser[3:0] == ST_INIT ||
      rsp_tuser[3:0] == ST_DESTROY),
      !rsp_tuser[4], "owner left after release")

endmodule

bind fifo_handoff_lock_unit fhl_checker u_fhl_checker (.*);

/* bench/fifo_handoff_lock_unit_tb.sv */
module fifo_handoff_lock_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fhl_pkg::*;

   localparam int WAIT_SLOTS = 16;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;    // requester[7:0]
   logic [1:0] req_tuser = 2'd0;    // action[1:0]
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // holder[7:0]
   logic [4:0] rsp_tuser;           // status[3:0], holder_valid[4]

   // no idling once this is set
   bit calm = 1'b0;
   int sent = 0;

   typedef struct packed {
      logic [3:0] status;
      logic       holder_valid;
      logic [7:0] holder;
   } lock_outcome_type;

   // mutex state mirror and the outcomes still owed by the unit
   class lock_scoreboard;
      bit               initialized;
      bit               held;
      logic [7:0]       owner;
      logic [7:0]       waiters[$];
      lock_outcome_type outcomes[$];
      int               failures;

      function new();
         initialized = 1'b0;
         held        = 1'b0;
         owner       = 8'd0;
         failures    = 0;
      endfunction

      function void note_request(logic [1:0] act, logic [7:0] who);
         lock_outcome_type o;
         logic [3:0]       st;
         case (act)
            ACT_INIT: begin
               held        = 1'b0;
               owner       = 8'd0;
               waiters.delete();
               initialized = 1'b1;
               st          = ST_INIT;
            end
            ACT_LOCK: begin
               if (!initialized) begin
                  st = ST_UNINIT;
               end else if (!held) begin
                  held  = 1'b1;
                  owner = who;
                  st    = ST_GRANTED;
               end else if (owner == who) begin
                  st = ST_GRANTED;
               end else if (waiters.size() >= WAIT_SLOTS) begin
                  st = ST_FULL;
               end else begin
                  waiters.push_back(who);
                  st = ST_QUEUED;
               end
            end
            ACT_UNLOCK: begin
               if (!initialized) begin
                  st = ST_UNINIT;
               end else if (!held) begin
                  st = ST_IGNORED;
               end else if (waiters.size() > 0) begin
                  owner = waiters.pop_front();
                  st    = ST_HANDED;
               end else begin
                  held  = 1'b0;
                  owner = 8'd0;
                  st    = ST_FREED;
               end
            end
            default: begin
               if (held) begin
                  st = ST_OWNED;
               end else begin
                  waiters.delete();
                  owner       = 8'd0;
                  initialized = 1'b0;
                  st          = ST_DESTROY;
               end
            end
         endcase
         o.status       = st;
         o.holder_valid = held;
         o.holder       = held ? owner : 8'd0;
         outcomes.push_back(o);
      endfunction

      function void check_result(logic [3:0] status, logic holder_valid, logic [7:0] holder);
         lock_outcome_type o;
         if (outcomes.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result: status %0d valid %0b holder %0d",
                        status, holder_valid, holder);
            return;
         end
         o = outcomes.pop_front();
         if (status !== o.status || holder_valid !== o.holder_valid ||
             holder !== o.holder) begin
            failures++;
            if (failures <= 10)
               $display("mismatch at %0t: status %0d/%0d valid %0b/%0b holder %0d/%0d",
                        $realtime, o.status, status, o.holder_valid, holder_valid,
                        o.holder, holder);
         end
      endfunction

      function int pending();
         return outcomes.size();
      endfunction
   endclass

   lock_scoreboard book = new();

   fifo_handoff_lock_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // result side back-pressure in bursts
   always @(negedge clock) begin
      static int stall_left = 0;
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         book.check_result(rsp_tuser[3:0], rsp_tuser[4], rsp_tdata);
   end

   // one request transaction, with an occasional gap before it
   task automatic push_request(input logic [1:0] act, input logic [7:0] who);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 3) == 0)
         gap = $urandom_range(1, 16);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= who;
      do @(posedge clock); while (!req_tready);
      book.note_request(act, who);
      sent++;
      if (sent >= 420)
         calm = 1'b1;
   endtask

   function automatic logic [1:0] pick_action();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4)
         return ACT_INIT;
      else if (r < 52)
         return ACT_LOCK;
      else if (r < 92)
         return ACT_UNLOCK;
      else
         return ACT_DESTROY;
   endfunction

   initial begin
      logic [7:0] crowd[4];
      int         n;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: uninitialised requests, owner relock, handoff order, reinit
      push_request(ACT_DESTROY, 8'h00);
      push_request(ACT_LOCK,    8'hFF);
      push_request(ACT_UNLOCK,  8'h00);
      push_request(ACT_INIT,    8'h00);
      push_request(ACT_UNLOCK,  8'h21);
      push_request(ACT_LOCK,    8'h00);
      push_request(ACT_LOCK,    8'h00);
      push_request(ACT_LOCK,    8'hFF);
      push_request(ACT_LOCK,    8'hAA);
      push_request(ACT_LOCK,    8'hFF);
      push_request(ACT_DESTROY, 8'h55);
      push_request(ACT_UNLOCK,  8'h55);
      push_request(ACT_UNLOCK,  8'hFF);
      push_request(ACT_UNLOCK,  8'hAA);
      push_request(ACT_UNLOCK,  8'hFF);
      push_request(ACT_UNLOCK,  8'h00);
      push_request(ACT_LOCK,    8'h80);
      push_request(ACT_LOCK,    8'h01);
      push_request(ACT_INIT,    8'h7F);
      push_request(ACT_LOCK,    8'h01);
      push_request(ACT_UNLOCK,  8'h01);
      push_request(ACT_DESTROY, 8'hFE);
      push_request(ACT_LOCK,    8'h55);
      push_request(ACT_INIT,    8'hFF);

      // random: queue fill and drain runs, and mixed traffic from a few threads
      while (sent < 520) begin
         for (int i = 0; i < 4; i++)
            crowd[i] = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 4) == 0) begin
            push_request(ACT_INIT, 8'($urandom_range(0, 255)));
            n = $urandom_range(17, 19);
            repeat (n) push_request(ACT_LOCK, 8'($urandom_range(0, 255)));
            n = $urandom_range(15, 19);
            repeat (n) push_request(ACT_UNLOCK, 8'($urandom_range(0, 255)));
            push_request(ACT_DESTROY, 8'($urandom_range(0, 255)));
         end else begin
            if ($urandom_range(0, 4) != 0)
               push_request(ACT_INIT, 8'($urandom_range(0, 255)));
            n = $urandom_range(10, 30);
            repeat (n) begin
               if ($urandom_range(0, 1) == 0)
                  push_request(pick_action(), crowd[2'($urandom_range(0, 3))]);
               else
                  push_request(pick_action(), 8'($urandom_range(0, 255)));
            end
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;

      // drain, then watch for stray results
      while (book.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);

      if (book.failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* fifo_handoff_lock_unit.f */
+incdir+rtl
rtl/fhl_pkg.sv
rtl/fhl_cell.sv
rtl/fhl_queue.sv
rtl/fifo_handoff_lock_unit.sv
rtl/fhl_checker.sv
bench/fifo_handoff_lock_unit_tb.sv
